@@ rtl/core/pqt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqt_pkg: shared types and constants of the periodic and queued one-shot timer
// Holds the word layouts, the command passed from front to back end and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package pqt_pkg;

    localparam int DELAY_W     = 16;
    localparam int IN_TAG_W    = 8;
    localparam int OUT_TAG_W   = 8;
    localparam int QCOUNT_W    = 3;
    localparam int PERIOD_W    = 32;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_ENABLE = 2'd1;
    localparam logic [PERIOD_W-1:0]  PERIOD_MS_RESET     = 32'd1000;

    // Command queue between front and back end.
    localparam int CMD_PTR_W   = 1;
    localparam int CMD_CNT_W   = 2;
    localparam logic [CMD_CNT_W-1:0] CMD_QUEUE_FULL = 2'd2;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_SCHED = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [DELAY_W-1:0]   delay;
        logic [IN_TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]  period_ms;
        logic                 periodic_enable;
    } cfg_t;

    // Result word, first member in the highest bits of the struct, so it is
    // packed into tdata field by field by the back end.
    typedef struct packed {
        logic                 periodic_fired;
        logic                 oneshot_fired;
        logic [OUT_TAG_W-1:0] fired_tag;
        logic                 request_started;
        logic                 request_queued;
        logic                 request_dropped;
        logic [QCOUNT_W-1:0]  queue_count;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/pqt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqt_front: input side of the timer
// Accepts input words, classifies them as tick or schedule commands and holds
// them in a two-entry command queue until the back end takes them.
// ----------------------------------------------------------------------------
module pqt_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pqt_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    output logic                                cmd_valid,
    output pqt_pkg::cmd_t                       cmd,
    input  wire logic                           cmd_pop
);

    pqt_pkg::cmd_t                      entry_reg [2];
    logic [pqt_pkg::CMD_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [pqt_pkg::CMD_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [pqt_pkg::CMD_CNT_W-1:0]      cnt_reg, cnt_next;
    pqt_pkg::cmd_t                      incoming;
    logic                               push;
    logic                               pop;

    always_comb begin
        incoming.kind  = s_tuser ? pqt_pkg::CMD_SCHED : pqt_pkg::CMD_TICK;
        incoming.delay = s_tdata[pqt_pkg::DELAY_W-1:0];
        incoming.tag   = s_tdata[pqt_pkg::DELAY_W +: pqt_pkg::IN_TAG_W];
    end

    assign s_tready  = (cnt_reg != pqt_pkg::CMD_QUEUE_FULL);
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pqt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqt_back: timer engine
// Carries out one command per cycle unless a result waits: steps the periodic
// and one-shot counters, runs the pending one-shot ring, registers the result.
// ----------------------------------------------------------------------------
module pqt_back #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire pqt_pkg::cfg_t                   cfg,
    input  wire logic                            cmd_valid,
    input  wire pqt_pkg::cmd_t                   cmd,
    output logic                                 cmd_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pqt_pkg::OUT_DATA_W-1:0]       m_tdata
);

    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = pqt_pkg::DELAY_W + TAG_BITS;
    localparam int WIDE_W  = 24;
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

    logic [pqt_pkg::PERIOD_W-1:0] pcount_reg, pcount_next;
    logic [pqt_pkg::DELAY_W-1:0]  ocount_reg, ocount_next;
    logic [pqt_pkg::DELAY_W-1:0]  target_reg, target_next;
    logic                         busy_reg, busy_next;
    logic [TAG_BITS-1:0]          atag_reg, atag_next;
    logic [PW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]                wr_ptr_reg, wr_ptr_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [pqt_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [ENTRY_W-1:0]           pending_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]           head_reg;
    logic                         mem_wr;
    logic [ENTRY_W-1:0]           mem_wdata;

    logic                         do_step;
    pqt_pkg::res_t                res;
    logic [pqt_pkg::PERIOD_W-1:0] period_eff;
    logic [pqt_pkg::PERIOD_W:0]   pcount_inc;
    logic [pqt_pkg::DELAY_W-1:0]  ocount_inc;
    logic [PW-1:0]                wr_ptr_inc;
    logic [PW-1:0]                rd_ptr_inc;
    logic [TAG_BITS-1:0]          cmd_tag;
    logic [WIDE_W-1:0]            cmd_tag_wide;
    logic [WIDE_W-1:0]            atag_wide;
    logic [pqt_pkg::DELAY_W-1:0]  head_delay;
    logic [TAG_BITS-1:0]          head_tag;
    logic [PW:0]                  qcount;
    logic [7:0]                   qcount_wide;

    assign do_step  = cmd_valid && (!m_tvalid_reg || m_tready);
    assign cmd_pop  = do_step;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cmd_tag_wide = WIDE_W'(cmd.tag);
    assign cmd_tag      = cmd_tag_wide[TAG_BITS-1:0];
    assign atag_wide    = WIDE_W'(atag_reg);
    assign head_delay   = head_reg[ENTRY_W-1 -: pqt_pkg::DELAY_W];
    assign head_tag     = head_reg[TAG_BITS-1:0];
    assign period_eff   = (cfg.period_ms == '0) ? 32'd1 : cfg.period_ms;
    assign pcount_inc   = {1'b0, pcount_reg} + 33'd1;
    assign ocount_inc   = ocount_reg + 16'd1;
    assign wr_ptr_inc   = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc   = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign mem_wdata    = {cmd.delay, cmd_tag};

    always_comb begin
        pcount_next = pcount_reg;
        ocount_next = ocount_reg;
        target_next = target_reg;
        busy_next   = busy_reg;
        atag_next   = atag_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mem_wr      = 1'b0;
        res         = '0;
        if (do_step) begin
            if (cmd.kind == pqt_pkg::CMD_TICK) begin
                if (cfg.periodic_enable) begin
                    if (pcount_inc >= {1'b0, period_eff}) begin
                        pcount_next        = '0;
                        res.periodic_fired = 1'b1;
                    end else begin
                        pcount_next = pcount_inc[pqt_pkg::PERIOD_W-1:0];
                    end
                end
                if (busy_reg) begin
                    if (ocount_inc >= target_reg) begin
                        res.oneshot_fired = 1'b1;
                        res.fired_tag     = atag_wide[pqt_pkg::OUT_TAG_W-1:0];
                        busy_next         = 1'b0;
                        ocount_next       = '0;
                        // The next pending one-shot starts on the expiring tick.
                        if (rd_ptr_reg != wr_ptr_reg) begin
                            rd_ptr_next = rd_ptr_inc;
                            target_next = (head_delay == '0) ? 16'd1 : head_delay;
                            busy_next   = 1'b1;
                            atag_next   = head_tag;
                        end
                    end else begin
                        ocount_next = ocount_inc;
                    end
                end
            end else if (!busy_reg) begin
                target_next         = (cmd.delay == '0) ? 16'd1 : cmd.delay;
                ocount_next         = '0;
                busy_next           = 1'b1;
                atag_next           = cmd_tag;
                res.request_started = 1'b1;
            end else if (wr_ptr_inc == rd_ptr_reg) begin
                res.request_dropped = 1'b1;
            end else begin
                mem_wr             = 1'b1;
                wr_ptr_next        = wr_ptr_inc;
                res.request_queued = 1'b1;
            end
        end
        if (wr_ptr_next >= rd_ptr_next) begin
            qcount = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        end else begin
            qcount = {1'b0, wr_ptr_next} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rd_ptr_next};
        end
        qcount_wide     = 8'(qcount);
        res.queue_count = qcount_wide[pqt_pkg::QCOUNT_W-1:0];
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (do_step) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg   <= '0;
            ocount_reg   <= '0;
            target_reg   <= '0;
            busy_reg     <= 1'b0;
            atag_reg     <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pcount_reg   <= pcount_next;
            ocount_reg   <= ocount_next;
            target_reg   <= target_next;
            busy_reg     <= busy_next;
            atag_reg     <= atag_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result word, highest bits first.
    always_ff @(posedge aclk) begin
        if (do_step) begin
            m_tdata_reg <= {res.queue_count, res.request_dropped, res.request_queued,
                            res.request_started, res.fired_tag, res.oneshot_fired,
                            res.periodic_fired};
        end
    end

    // Pending ring. The head register always holds the entry at the read
    // pointer; a write to the slot about to become the head is forwarded.
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            pending_mem[wr_ptr_reg] <= mem_wdata;
        end
        if (mem_wr && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= mem_wdata;
        end else begin
            head_reg <= pending_mem[rd_ptr_next];
        end
    end

    // An idle one-shot unit never leaves anything in the ring.
    a_idle_ring_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("one-shot idle with pending entries in the ring");

    a_count_below_target: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (ocount_reg < target_reg))
        else $error("one-shot count reached its target while still busy");

    a_drop_keeps_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_step && res.request_dropped) |=> ($stable(wr_ptr_reg) && $stable(rd_ptr_reg)))
        else $error("dropped request moved the ring pointers");

endmodule

`default_nettype wire

@@ rtl/core/periodic_and_queued_oneshot_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_and_queued_oneshot_timer: periodic timer plus queued one-shot timer
// Top level: configuration registers, front end with command queue and the
// timer engine.
// ----------------------------------------------------------------------------
// Every input word is either a one millisecond tick (s_tuser low) or a request
// to schedule a one-shot (s_tuser high), and every input word yields exactly
// one result word, in order. The block sustains one word per cycle while its
// result words are taken. An accepted word is written into the two-entry
// command queue of the front end at the accepting edge, the timer engine
// updates from the queue head once its output register is free, and that
// output register then holds the result word until it is taken. The front end
// keeps accepting while a result waits, until its queue is full. Pending
// one-shots live in a ring of QUEUE_DEPTH slots with one slot always kept free,
// stored in a memory whose head entry is prefetched into a register; no
// clearing pass is needed after reset. The periodic timer fires on every
// period_ms-th enabled tick (a period of zero acts as one), and a one-shot
// delay of zero counts as one tick. Configuration writes take effect on the
// next clock edge and should be made while no words are in flight.
// ----------------------------------------------------------------------------
module periodic_and_queued_oneshot_timer #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_wr_en,
    input  wire logic [pqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pqt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input words.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [15:0] delay, [23:16] event_tag
    input  wire logic [pqt_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] req_type: low for a tick, high for a schedule request
    input  wire logic                             s_tuser,
    // Result words.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] periodic_fired, [1] oneshot_fired, [9:2] fired_tag,
    // [10] request_started, [11] request_queued, [12] request_dropped,
    // [15:13] queue_count
    output logic [pqt_pkg::OUT_DATA_W-1:0]        m_tdata
);

    pqt_pkg::cfg_t  cfg_reg;
    pqt_pkg::cfg_t  cfg_next;
    logic           cmd_valid;
    pqt_pkg::cmd_t  cmd;
    logic           cmd_pop;

    // Register writes to indexes beyond the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                pqt_pkg::CFG_PERIOD_MS: begin
                    cfg_next.period_ms = cfg_wdata;
                end
                pqt_pkg::CFG_PERIODIC_ENABLE: begin
                    cfg_next.periodic_enable = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_ms       <= pqt_pkg::PERIOD_MS_RESET;
            cfg_reg.periodic_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pqt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pqt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
